[rtl/smsq_pkg.sv]
// shared types, codes and constants of the smbus master transfer sequencer
package smsq_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int BUF_AW       = 5;
    localparam int LEN_W        = 6;

    localparam logic [7:0] DIR_MASK        = 8'hFE;
    localparam logic [7:0] CFG_RESET_VALUE = 8'd10;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;
    localparam logic [LEN_W-1:0] SENT_MAX  = '1;

    localparam logic [2:0] OP_LOAD    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_EVENT   = 3'd3;
    localparam logic [2:0] OP_DISABLE = 3'd4;

    localparam logic [3:0] SC_START         = 4'd0;
    localparam logic [3:0] SC_REP_START     = 4'd1;
    localparam logic [3:0] SC_MT_ADDR_ACK   = 4'd2;
    localparam logic [3:0] SC_MT_ADDR_NACK  = 4'd3;
    localparam logic [3:0] SC_MT_DATA_ACK   = 4'd4;
    localparam logic [3:0] SC_MT_DATA_NACK  = 4'd5;
    localparam logic [3:0] SC_MR_ADDR_ACK   = 4'd6;
    localparam logic [3:0] SC_MR_ADDR_NACK  = 4'd7;
    localparam logic [3:0] SC_MR_DATA_ACK   = 4'd8;
    localparam logic [3:0] SC_MR_DATA_NACK  = 4'd9;
    localparam logic [3:0] SC_ARB_LOST      = 4'd10;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;

    localparam logic [2:0] RETRY_MT_ADDR = 3'b001;
    localparam logic [2:0] RETRY_MT_DATA = 3'b010;
    localparam logic [2:0] RETRY_ARB     = 3'b100;

    localparam logic CFG_READ_NACK_LIMIT = 1'b0;
    localparam logic CFG_FAIL_GRACE      = 1'b1;

    typedef struct packed {
        logic [2:0]        operation;
        logic [3:0]        status_code;
        logic [7:0]        slave_address;
        logic [LEN_W-1:0]  transfer_length;
        logic [BUF_AW-1:0] buffer_index;
        logic [7:0]        data_byte;
    } t_item;

    typedef struct packed {
        logic              device_fail;
        logic              read_done;
        logic [7:0]        rx_byte;
        logic [BUF_AW-1:0] rx_index;
        logic              rx_valid;
        logic              bus_held;
        logic              engine_reset;
        logic [1:0]        ack_action;
        logic [1:0]        stop_action;
        logic [1:0]        start_action;
        logic              tx_valid;
        logic [7:0]        tx_byte;
    } t_result;

endpackage

[rtl/smsq_core.sv]
// sequencer state, transmit buffer and per-request decision logic
module smsq_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  smsq_pkg::t_item    i_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_wdata,
    output smsq_pkg::t_result  o_result
);

    logic [7:0] r_nack_limit, r_grace_limit;
    logic [7:0] r_target, n_target;
    logic [7:0] r_checked, n_checked;
    logic       r_dir, n_dir;
    logic       r_busy, n_busy;
    logic [smsq_pkg::LEN_W-1:0] r_wlen, n_wlen;
    logic [smsq_pkg::LEN_W-1:0] r_rlen, n_rlen;
    logic [smsq_pkg::LEN_W-1:0] r_sent, n_sent;
    logic [smsq_pkg::LEN_W-1:0] r_rcvd, n_rcvd;
    logic [2:0] r_retry, n_retry;
    logic [7:0] r_nack_cnt, n_nack_cnt;
    logic [7:0] r_grace_cnt, n_grace_cnt;
    logic [7:0] r_buf [smsq_pkg::BUFFER_DEPTH];

    logic [smsq_pkg::LEN_W-1:0] sent_pos, rx_pos, clip_len, sent_inc;
    logic [7:0]                 slot_byte;
    logic                       slot_ok, fail, retry_hit, send_addr, send_slot;
    logic [2:0]                 retry_bit;
    smsq_pkg::t_result          res;

    always_comb begin
        n_target    = r_target;
        n_checked   = r_checked;
        n_dir       = r_dir;
        n_busy      = r_busy;
        n_wlen      = r_wlen;
        n_rlen      = r_rlen;
        n_sent      = r_sent;
        n_rcvd      = r_rcvd;
        n_retry     = r_retry;
        n_nack_cnt  = r_nack_cnt;
        n_grace_cnt = r_grace_cnt;
        res         = '0;
        fail        = 1'b0;
        send_addr   = 1'b0;
        send_slot   = 1'b0;
        retry_bit   = 3'b000;

        sent_pos  = r_sent - smsq_pkg::LEN_W'(1);
        rx_pos    = r_rcvd - smsq_pkg::LEN_W'(1);
        slot_ok   = (r_sent != '0) && (sent_pos < smsq_pkg::LEN_W'(smsq_pkg::BUFFER_DEPTH));
        slot_byte = slot_ok ? r_buf[sent_pos[smsq_pkg::BUF_AW-1:0]] : 8'h00;
        sent_inc  = (r_sent == smsq_pkg::SENT_MAX) ? r_sent : r_sent + smsq_pkg::LEN_W'(1);
        clip_len  = (i_item.transfer_length > smsq_pkg::LEN_W'(smsq_pkg::BUFFER_DEPTH)) ?
                    smsq_pkg::LEN_W'(smsq_pkg::BUFFER_DEPTH) : i_item.transfer_length;

        case (i_item.operation)
            smsq_pkg::OP_WRITE, smsq_pkg::OP_READ: begin
                n_target = i_item.slave_address;
                if (i_item.operation == smsq_pkg::OP_WRITE) begin
                    n_wlen = clip_len;
                    n_dir  = 1'b0;
                end else begin
                    n_rlen = clip_len;
                    n_dir  = 1'b1;
                end
                n_busy           = 1'b1;
                res.start_action = smsq_pkg::ACT_SET;
            end
            smsq_pkg::OP_EVENT: begin
                case (i_item.status_code)
                    smsq_pkg::SC_START: begin
                        send_addr = 1'b1;
                        n_checked = r_target;
                    end
                    smsq_pkg::SC_REP_START:  send_addr = 1'b1;
                    smsq_pkg::SC_MT_ADDR_ACK: send_slot = 1'b1;
                    smsq_pkg::SC_MT_ADDR_NACK: retry_bit = smsq_pkg::RETRY_MT_ADDR;
                    smsq_pkg::SC_MT_DATA_ACK: begin
                        if (r_sent <= r_wlen) begin
                            send_slot = 1'b1;
                        end else begin
                            res.stop_action = smsq_pkg::ACT_SET;
                            n_busy          = 1'b0;
                        end
                    end
                    smsq_pkg::SC_MT_DATA_NACK: retry_bit = smsq_pkg::RETRY_MT_DATA;
                    smsq_pkg::SC_MR_ADDR_ACK: begin
                        res.ack_action = (r_rcvd == r_rlen) ? smsq_pkg::ACT_CLEAR
                                                            : smsq_pkg::ACT_SET;
                    end
                    smsq_pkg::SC_MR_ADDR_NACK: begin
                        if (r_nack_cnt > r_nack_limit) begin
                            res.device_fail = (r_grace_cnt > r_grace_limit);
                            if (r_grace_cnt != smsq_pkg::COUNT_MAX) begin
                                n_grace_cnt = r_grace_cnt + 8'd1;
                            end
                            n_nack_cnt = '0;
                            fail       = 1'b1;
                        end else begin
                            if (r_nack_cnt != smsq_pkg::COUNT_MAX) begin
                                n_nack_cnt = r_nack_cnt + 8'd1;
                            end
                            res.start_action = smsq_pkg::ACT_SET;
                        end
                    end
                    smsq_pkg::SC_MR_DATA_ACK: begin
                        if ((r_rcvd != '0) && (r_rcvd < r_rlen)) begin
                            res.rx_valid   = 1'b1;
                            res.rx_index   = rx_pos[smsq_pkg::BUF_AW-1:0];
                            res.rx_byte    = i_item.data_byte;
                            res.ack_action = (r_rcvd == r_rlen - smsq_pkg::LEN_W'(1)) ?
                                             smsq_pkg::ACT_CLEAR : smsq_pkg::ACT_SET;
                            n_rcvd         = r_rcvd + smsq_pkg::LEN_W'(1);
                        end
                    end
                    smsq_pkg::SC_MR_DATA_NACK: begin
                        if (r_rcvd != '0) begin
                            res.rx_valid = 1'b1;
                            res.rx_index = rx_pos[smsq_pkg::BUF_AW-1:0];
                            res.rx_byte  = i_item.data_byte;
                        end
                        res.stop_action = smsq_pkg::ACT_SET;
                        res.ack_action  = smsq_pkg::ACT_SET;
                        res.read_done   = 1'b1;
                        n_busy          = 1'b0;
                        n_grace_cnt     = '0;
                        n_nack_cnt      = '0;
                    end
                    smsq_pkg::SC_ARB_LOST: retry_bit = smsq_pkg::RETRY_ARB;
                    default: fail = 1'b1;
                endcase
            end
            smsq_pkg::OP_DISABLE: fail = 1'b1;
            default: ;
        endcase

        // one retry per write-side nack kind or arbitration loss
        retry_hit = (retry_bit != '0) && ((r_retry & retry_bit) != '0);
        if (retry_bit != '0) begin
            if (retry_hit) begin
                n_retry = r_retry & ~retry_bit;
                fail    = 1'b1;
            end else begin
                n_retry          = r_retry | retry_bit;
                res.start_action = smsq_pkg::ACT_SET;
            end
        end

        if (send_addr) begin
            res.tx_byte      = (r_target & smsq_pkg::DIR_MASK) | {7'd0, r_dir};
            res.tx_valid     = 1'b1;
            res.start_action = smsq_pkg::ACT_CLEAR;
            n_rcvd           = smsq_pkg::LEN_W'(1);
            n_sent           = smsq_pkg::LEN_W'(1);
        end

        if (send_slot) begin
            res.tx_byte  = slot_byte;
            res.tx_valid = 1'b1;
            n_sent       = sent_inc;
        end

        if (fail) begin
            res.engine_reset = 1'b1;
            res.start_action = smsq_pkg::ACT_CLEAR;
            res.stop_action  = smsq_pkg::ACT_CLEAR;
            res.ack_action   = smsq_pkg::ACT_CLEAR;
            n_busy           = 1'b0;
        end

        res.bus_held = n_busy;
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nack_limit  <= smsq_pkg::CFG_RESET_VALUE;
            r_grace_limit <= smsq_pkg::CFG_RESET_VALUE;
        end else if (i_cfg_we) begin
            if (i_cfg_index == smsq_pkg::CFG_READ_NACK_LIMIT) begin
                r_nack_limit <= i_cfg_wdata;
            end
            if (i_cfg_index == smsq_pkg::CFG_FAIL_GRACE) begin
                r_grace_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_checked   <= '0;
            r_dir       <= 1'b0;
            r_busy      <= 1'b0;
            r_wlen      <= '0;
            r_rlen      <= '0;
            r_sent      <= '0;
            r_rcvd      <= '0;
            r_retry     <= '0;
            r_nack_cnt  <= '0;
            r_grace_cnt <= '0;
        end else if (i_fire) begin
            r_target    <= n_target;
            r_checked   <= n_checked;
            r_dir       <= n_dir;
            r_busy      <= n_busy;
            r_wlen      <= n_wlen;
            r_rlen      <= n_rlen;
            r_sent      <= n_sent;
            r_rcvd      <= n_rcvd;
            r_retry     <= n_retry;
            r_nack_cnt  <= n_nack_cnt;
            r_grace_cnt <= n_grace_cnt;
        end
    end

    // transmit buffer, no reset
    always_ff @(posedge i_clk) begin
        if (i_fire && (i_item.operation == smsq_pkg::OP_LOAD)) begin
            r_buf[i_item.buffer_index] <= i_item.data_byte;
        end
    end

    a_fail_frees_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && fail) |=> !r_busy)
        else $error("failure left the bus claimed");

    a_start_claims_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && ((i_item.operation == smsq_pkg::OP_WRITE) ||
                    (i_item.operation == smsq_pkg::OP_READ))) |=> r_busy)
        else $error("transfer start did not claim the bus");

    a_rcvd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcvd <= smsq_pkg::LEN_W'(smsq_pkg::BUFFER_DEPTH))
        else $error("receive count beyond buffer depth");

endmodule

[rtl/smbus_master_transfer_sequencer_top.sv]
// top level of the smbus master transfer sequencer: stream ports and pipeline registers
//
// channel   | ports                        | contents
// ----------+------------------------------+------------------------------------------
// request   | i_s_axis_t*, o_s_axis_tready | tuser: operation; tdata: status, address,
//           |                              |   length, buffer index, data byte
// result    | o_m_axis_t*, i_m_axis_tready | tdata: one result per request
// config    | i_cfg_we, i_cfg_index, data  | 0 read nack limit, 1 fail report grace
//
// one request per cycle sustained while results are accepted; a taken request goes through
// the input register, then decision logic into the result register, where it is offered
// the input register keeps taking requests while a result waits, until both stages are full
// synchronous active-low reset clears sequencer state; both limits return to 10

module smbus_master_transfer_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // status_code, slave_address, transfer_length,
                                          // buffer_index, data_byte, zero pad
    input  logic [2:0]  i_s_axis_tuser,   // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // tx_byte, tx_valid, start_action, stop_action,
                                          // ack_action, engine_reset, bus_held, rx_valid,
                                          // rx_index, rx_byte, read_done, device_fail, pad
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    logic              r_in_valid;
    smsq_pkg::t_item   r_in;
    logic              r_out_valid;
    smsq_pkg::t_result r_out;
    smsq_pkg::t_result core_result;
    smsq_pkg::t_item   in_item;
    logic              advance;
    logic              in_take;

    assign in_item.operation       = i_s_axis_tuser;
    assign in_item.status_code     = i_s_axis_tdata[3:0];
    assign in_item.slave_address   = i_s_axis_tdata[11:4];
    assign in_item.transfer_length = i_s_axis_tdata[17:12];
    assign in_item.buffer_index    = i_s_axis_tdata[22:18];
    assign in_item.data_byte       = i_s_axis_tdata[30:23];

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    smsq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (r_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, 33'(r_out)};

    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_done) |->
            (!r_out.bus_held && (r_out.stop_action == smsq_pkg::ACT_SET)))
        else $error("read completion without stop and bus release");

    a_fail_with_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.device_fail) |-> (r_out.engine_reset && !r_out.bus_held))
        else $error("device failure reported without engine reset");

    a_rx_tx_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.rx_valid && r_out.tx_valid))
        else $error("transmit and receive byte in one result");

    a_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("pending request dropped");

endmodule
